// ===== hdl/polyval_accumulator_macros.svh =====
// Assertion macros shared by the POLYVAL accumulator RTL.
`ifndef POLYVAL_ACCUMULATOR_MACROS_SVH
`define POLYVAL_ACCUMULATOR_MACROS_SVH

`ifndef SYNTH
// Same-cycle implication, sampled on i_clk, off during reset.
`define PV_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("pval assertion failed");
// Next-cycle implication, sampled on i_clk, off during reset.
`define PV_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("pval assertion failed");
`else
`define PV_ASSERT_SAME(lbl, ante, cons)
`define PV_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ===== hdl/pval_pkg.sv =====
// Types and constants shared by the POLYVAL accumulator modules.
`timescale 1ns / 1ps
`default_nettype none

package pval_pkg;

    localparam int unsigned BlkW    = 128;
    localparam int unsigned HalfW   = 64;
    localparam int unsigned CntW    = 5;
    localparam int unsigned NumByte = BlkW / 8;
    localparam int unsigned SDataW  = 136;   // two halves, count, zero pad to bytes

    typedef logic [BlkW-1:0] t_blk;

    typedef enum logic [0:0] {
        OP_ABSORB = 1'b0,
        OP_FINISH = 1'b1
    } t_op;

    typedef enum logic [0:0] {
        REG_KEY_LOW  = 1'b0,
        REG_KEY_HIGH = 1'b1
    } t_reg_idx;

endpackage

`default_nettype wire

// ===== hdl/pval_gfmul.sv =====
// GF(2^128) POLYVAL product a*b*x^-128 mod x^128+x^127+x^126+x^121+1, combinational.
`timescale 1ns / 1ps
`default_nettype none

module pval_gfmul
    import pval_pkg::*;
(
    input  wire t_blk i_a,
    input  wire t_blk i_b,
    output t_blk      o_p
);

    // Carry-less 128x128 product; partial products are independent and XOR-reduced.
    function automatic logic [2*BlkW-1:0] clmul(input t_blk a, input t_blk b);
        logic [2*BlkW-1:0] acc;
        acc = '0;
        for (int i = 0; i < BlkW; i++) begin
            if (a[i]) begin
                acc = acc ^ ({{BlkW{1'b0}}, b} << i);
            end
        end
        return acc;
    endfunction

    logic [2*BlkW-1:0] prod;
    t_blk              prod_lo;
    t_blk              prod_hi;
    t_blk              fold;

    assign prod    = clmul(i_a, i_b);
    assign prod_lo = prod[BlkW-1:0];
    assign prod_hi = prod[2*BlkW-1:BlkW];

    // Montgomery fold: m = lo * P^-1 mod x^128. Shifted-in bits all come from
    // lo[6:0], below the lowest tap, so one pass is exact.
    assign fold = prod_lo ^ (prod_lo << 121) ^ (prod_lo << 126) ^ (prod_lo << 127);

    // (lo + m*P) / x^128 leaves only the upper taps of m*P.
    assign o_p = prod_hi ^ fold ^ (fold >> 1) ^ (fold >> 2) ^ (fold >> 7);

endmodule

`default_nettype wire

// ===== hdl/polyval_accumulator.sv =====
// POLYVAL accumulator top level: input register, GF multiply, accumulator and tag registers.
//
// POLYVAL hash engine (RFC 8452). Each input beat carries a 16-byte block
// with a valid-byte count (bytes past the count read as zero, counts above
// 16 mean all 16). An absorb beat folds the block into the accumulator and
// multiplies by the key H (acc = (acc ^ blk) * H * x^-128); a zero count
// leaves the accumulator alone. A finish beat XORs its nonce in, emits the
// tag on the master side and clears the accumulator. The multiply and
// reduction sit between the input register and the accumulator register;
// the tag register loads acc ^ block, so a finish beat passes through the
// input register and then the tag register. One beat is taken every
// cycle unless the tag register, which holds one result, is full and
// stalled; then a waiting finish beat holds the input register and
// s_axis_tready follows m_axis_tready. Key writes go through the cfg port
// only while idle (the user's duty, not enforced); they apply from the next absorb beat.
`timescale 1ns / 1ps
`default_nettype none

`include "polyval_accumulator_macros.svh"

module polyval_accumulator
    import pval_pkg::*;
(
    input  wire                i_clk,
    input  wire                i_rst_n,

    input  wire                i_cfg_wr_en,
    input  wire [0:0]          i_cfg_index,
    input  wire [HalfW-1:0]    i_cfg_data,

    input  wire                s_axis_tvalid,
    output logic               s_axis_tready,
    // [63:0] block_low, [127:64] block_high, [132:128] byte_count, [135:133] zero
    input  wire [SDataW-1:0]   s_axis_tdata,
    // [0] op
    input  wire [0:0]          s_axis_tuser,

    output logic               m_axis_tvalid,
    input  wire                m_axis_tready,
    // [63:0] tag_low, [127:64] tag_high
    output logic [BlkW-1:0]    m_axis_tdata
);

    logic [HalfW-1:0] r_key_low;
    logic [HalfW-1:0] r_key_high;

    logic             r_in_valid;
    t_op              r_in_op;
    t_blk             r_in_blk;
    logic [CntW-1:0]  r_in_cnt;

    t_blk             r_acc;
    t_blk             n_acc;
    logic             r_out_valid;
    t_blk             r_out_data;

    t_blk             byte_mask;
    t_blk             data_in;
    t_blk             acc_mix;
    t_blk             prod;
    logic             out_free;
    logic             adv;
    logic             do_finish;
    logic             s_beat;

    // key registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_low  <= '0;
            r_key_high <= '0;
        end else if (i_cfg_wr_en) begin
            unique case (t_reg_idx'(i_cfg_index))
                REG_KEY_LOW:  r_key_low  <= i_cfg_data;
                REG_KEY_HIGH: r_key_high <= i_cfg_data;
                default:      r_key_low  <= r_key_low;
            endcase
        end
    end

    assign out_free      = !r_out_valid || m_axis_tready;
    assign adv           = r_in_valid && ((r_in_op == OP_ABSORB) || out_free);
    assign do_finish     = adv && (r_in_op == OP_FINISH);
    assign s_axis_tready = !r_in_valid || adv;
    assign s_beat        = s_axis_tvalid && s_axis_tready;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_beat) begin
            r_in_op  <= t_op'(s_axis_tuser[0]);
            r_in_blk <= s_axis_tdata[BlkW-1:0];
            r_in_cnt <= s_axis_tdata[BlkW+CntW-1:BlkW];
        end
    end

    // byte i survives when count > i; counts of 16 and up keep everything
    always_comb begin
        for (int i = 0; i < NumByte; i++) begin
            byte_mask[8*i +: 8] = {8{r_in_cnt > CntW'(i)}};
        end
    end

    assign data_in = r_in_blk & byte_mask;
    assign acc_mix = r_acc ^ data_in;

    pval_gfmul u_gfmul (
        .i_a (acc_mix),
        .i_b ({r_key_high, r_key_low}),
        .o_p (prod)
    );

    always_comb begin
        n_acc = r_acc;
        if (adv) begin
            unique case (r_in_op)
                OP_FINISH: n_acc = '0;
                OP_ABSORB: n_acc = (r_in_cnt == '0) ? r_acc : prod;
                default:   n_acc = r_acc;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
        end else begin
            r_acc <= n_acc;
        end
    end

    // tag register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (do_finish) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_finish) begin
            r_out_data <= acc_mix;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    `PV_ASSERT_NEXT(a_finish_clears, do_finish, r_acc == '0)
    `PV_ASSERT_NEXT(a_empty_absorb_holds,
        adv && (r_in_op == OP_ABSORB) && (r_in_cnt == '0), $stable(r_acc))
    `PV_ASSERT_NEXT(a_tag_only_from_finish, !r_out_valid && !do_finish, !r_out_valid)
    `PV_ASSERT_SAME(a_stalled_finish_holds,
        r_in_valid && (r_in_op == OP_FINISH) && r_out_valid && !m_axis_tready,
        !s_axis_tready)

endmodule

`default_nettype wire
